// ----- hdl/sha256_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, constants and a rotate helper.
// ----------------------------------------------------------------------------
package sha256_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_item_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
		logic        status;
	} out_item_t;

	typedef enum logic [1:0] {
		CFG_NORM_EN  = 2'd0,
		CFG_NORM_OFS = 2'd1,
		CFG_MIN_LEN  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// compression engine control and status
	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} cmp_ctl_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RC [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

endpackage

// ----- hdl/sha256_round.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 round engine
// One round per cycle with a rolling 16-word schedule; folds into the
// chaining value after 64 rounds.
// ----------------------------------------------------------------------------
module sha256_round
	import sha256_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  cmp_ctl_t      ctl_in,
	input  logic [511:0]  block,
	input  logic          init_cv,
	output cmp_ctl_t      ctl_out,
	output logic [255:0]  cv
);

	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] cv_q [8];
	logic [5:0]  rnd_q;
	logic        busy_q;
	logic        done_q;

	logic [31:0] s0, s1, wn, t1, t2, e, a;

	always_comb begin
		e  = v_q[4];
		a  = v_q[0];
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
		t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + RC[rnd_q] + w_q[0];
		t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start && !busy_q) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// working variables, schedule, chaining value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
		end else if (init_cv) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= IV[i];
		end else if (ctl_in.start && !busy_q) begin
			for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
			for (int i = 0; i < 8; i++) v_q[i] <= cv_q[i];
		end else if (busy_q) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end else if (done_q) begin
			for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] + v_q[i];
		end
	end

	// fold happens the cycle after done; done is reported through the fold_q register
	logic fold_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fold_q <= 1'b0;
		else         fold_q <= done_q;
	end

	always_comb begin
		ctl_out.start = 1'b0;
		ctl_out.busy  = busy_q | done_q;
		ctl_out.done  = fold_q;
		for (int i = 0; i < 8; i++) cv[255 - 32*i -: 32] = cv_q[i];
	end

endmodule

// ----- hdl/sha256_stream_hasher_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Byte-wide message input, 64-bit digest words out.
// ----------------------------------------------------------------------------
// A byte that does not fill a block leaves the core idle; a byte that completes
// a block holds off the input while the block is loaded, run through 64 rounds,
// folded and reported done. End of message: padding is written one byte per
// cycle plus one or two blocks of rounds, then four result words. Reset returns
// to initial values immediately; the block buffer is not cleared.
module sha256_stream_hasher_core
	import sha256_pkg::*;
#(
	parameter int LENGTH_WIDTH = 61
)(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	state_t state_q, state_d;

	logic       norm_en_q;
	logic [7:0] norm_ofs_q, min_len_q;

	logic [511:0]            blk_q;   // byte shift register, first byte ends on top
	logic [6:0]              fill_q;
	logic [LENGTH_WIDTH-1:0] len_q;
	logic                    fin_q;
	logic                    tail_q;  // length bytes placed
	logic [3:0]              pad_i_q;
	logic [1:0]              word_q;
	logic                    err_q;

	cmp_ctl_t    ctl_in, ctl_out;
	logic        init_cv;
	logic [255:0] cv;
	logic [63:0]  bits;

	always_comb begin
		bits = 64'(len_q) << 3;
	end

	sha256_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_in),
		.block   (blk_q),
		.init_cv (init_cv),
		.ctl_out (ctl_out),
		.cv      (cv)
	);

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_en_q  <= 1'b0;
			norm_ofs_q <= '0;
			min_len_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NORM_EN:  norm_en_q  <= cfg_data[0];
				CFG_NORM_OFS: norm_ofs_q <= cfg_data;
				CFG_MIN_LEN:  min_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic accept, emit_done, short_msg;
	logic [LENGTH_WIDTH-1:0] len_nx;
	logic [7:0] pad_byte;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = (state_q == ST_EMIT);
	assign emit_done = out_valid && out_ready && (err_q || word_q == 2'd3);
	assign len_nx    = len_q + LENGTH_WIDTH'(in_data.has_byte);
	assign short_msg = norm_en_q && (len_nx < LENGTH_WIDTH'(min_len_q));

	// padding byte for the current slot
	always_comb begin
		if (!tail_q && pad_i_q == 4'd0 && fill_q[5:0] == 6'd0 && !fin_q)
			pad_byte = 8'h00;
		else if (fill_q[5:0] >= 6'd56 && tail_q)
			pad_byte = bits[63 - 8*(fill_q[2:0]) -: 8];
		else
			pad_byte = 8'h00;
	end

	always_comb begin
		out_data.digest_word = err_q ? 64'd0 : cv[255 - 64*word_q -: 64];
		out_data.word_index  = err_q ? 2'd0 : word_q;
		out_data.last_word   = err_q || word_q == 2'd3;
		out_data.status      = err_q;
	end

	// next state
	always_comb begin
		state_d       = state_q;
		ctl_in        = '0;
		init_cv       = 1'b0;
		unique case (state_q)
			ST_IDLE: if (accept) begin
				if (in_data.end_of_message && short_msg) state_d = ST_EMIT;
				else if (in_data.has_byte && fill_q == 7'd63) state_d = ST_LOAD;
				else if (in_data.end_of_message) state_d = ST_PAD;
			end
			ST_LOAD: begin
				ctl_in.start = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: if (ctl_out.done) begin
				if (!fin_q) state_d = ST_IDLE;
				else if (tail_q && fill_q == 7'd0) state_d = ST_EMIT;
				else state_d = ST_PAD;
			end
			ST_PAD: if (fill_q == 7'd63) state_d = ST_LOAD;
			ST_FOLD: state_d = ST_IDLE;
			ST_EMIT: if (emit_done) begin
				init_cv = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// datapath: buffer fill, length, padding sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			len_q   <= '0;
			fin_q   <= 1'b0;
			tail_q  <= 1'b0;
			pad_i_q <= '0;
			word_q  <= '0;
			err_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (accept) begin
					if (in_data.has_byte) begin
						blk_q <= {blk_q[503:0], (norm_en_q &&
							len_q == LENGTH_WIDTH'(norm_ofs_q)) ? 8'h00 : in_data.data_byte};
						fill_q <= (fill_q == 7'd63) ? 7'd0 : fill_q + 7'd1;
						len_q  <= len_nx;
					end
					fin_q   <= in_data.end_of_message;
					tail_q  <= 1'b0;
					pad_i_q <= '0;
					word_q  <= '0;
					err_q   <= in_data.end_of_message && short_msg;
				end
				ST_PAD: begin
					// first pad byte is 0x80, then zeros, then length in last 8 slots
					if (pad_i_q == 4'd0) begin
						blk_q <= {blk_q[503:0], PAD_BYTE};
						pad_i_q <= 4'd1;
					end else if (fill_q >= 7'd56 && pad_i_q == 4'd2) begin
						blk_q <= {blk_q[503:0], bits[63 - 8*(fill_q[2:0]) -: 8]};
						if (fill_q == 7'd63) tail_q <= 1'b1;
					end else begin
						blk_q <= {blk_q[503:0], pad_byte};
					end
					if (pad_i_q != 4'd0 && fill_q == 7'd55) pad_i_q <= 4'd2;
					if (pad_i_q == 4'd0 && fill_q == 7'd55) pad_i_q <= 4'd2;
					fill_q <= (fill_q == 7'd63) ? 7'd0 : fill_q + 7'd1;
				end
				ST_EMIT: if (out_ready) begin
					word_q <= word_q + 2'd1;
					if (emit_done) begin
						fill_q <= '0;
						len_q  <= '0;
						fin_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

endmodule
